/* rtl/s5hp_pkg.sv */
// Shared types and constants for the SOCKS5 server handshake parser.
// No dependencies; imported by socks5_server_handshake_parser_unit.
package s5hp_pkg;

	// Protocol byte values
	localparam logic [7:0] SOCKS_VER      = 8'h05;
	localparam logic [7:0] METHOD_NOAUTH  = 8'h00;
	localparam logic [7:0] METHOD_NONE    = 8'hFF;
	localparam logic [7:0] CMD_CONNECT    = 8'h01;
	localparam logic [7:0] ATYP_IPV4      = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
	localparam logic [7:0] ATYP_IPV6      = 8'h04;
	localparam logic [7:0] REP_SUCCEEDED  = 8'h00;
	localparam logic [7:0] REP_CMD_UNSUP  = 8'h07;
	localparam logic [7:0] REP_ATYP_UNSUP = 8'h08;
	localparam logic [7:0] IPV4_ADDR_LEN  = 8'd4;
	localparam logic [7:0] IPV6_ADDR_LEN  = 8'd16;

	// Result kinds
	localparam logic [1:0] KIND_REPLY   = 2'd0;
	localparam logic [1:0] KIND_ADDR    = 2'd1;
	localparam logic [1:0] KIND_OUTCOME = 2'd2;

	// Address types as reported
	localparam logic [1:0] AT_IPV4   = 2'd0;
	localparam logic [1:0] AT_DOMAIN = 2'd1;
	localparam logic [1:0] AT_IPV6   = 2'd2;

	// Outcome codes
	localparam logic [2:0] OC_READY    = 3'd0;
	localparam logic [2:0] OC_BAD_VER  = 3'd1;
	localparam logic [2:0] OC_NO_METH  = 3'd2;
	localparam logic [2:0] OC_BAD_CMD  = 3'd3;
	localparam logic [2:0] OC_BAD_ATYP = 3'd4;
	localparam logic [2:0] OC_CLOSED   = 3'd5;

	// Result bursts one transaction can cause
	typedef enum logic [2:0] {
		BURST_NONE,    // no result
		BURST_ADDR,    // one address byte
		BURST_FIN,     // outcome only
		BURST_REJECT,  // 05 FF, outcome
		BURST_ACCEPT,  // 05 00
		BURST_REPLY10  // ten reply bytes, outcome
	} burst_t;

	localparam int unsigned IDX_W = 4;

	// Index of the final result of a burst
	function automatic logic [IDX_W-1:0] burst_last_idx(input burst_t bt);
		logic [IDX_W-1:0] r;
		case (bt)
			BURST_REJECT:  r = 4'd2;
			BURST_ACCEPT:  r = 4'd1;
			BURST_REPLY10: r = 4'd10;
			default:       r = 4'd0;
		endcase
		return r;
	endfunction

	// Byte of the ten-byte request reply: 05 REP 00 01 00 00 00 00 00 00
	function automatic logic [7:0] reply10_byte(input logic [IDX_W-1:0] idx,
			input logic [7:0] code);
		logic [7:0] r;
		case (idx)
			4'd0:    r = SOCKS_VER;
			4'd1:    r = code;
			4'd3:    r = 8'h01;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* rtl/socks5_server_handshake_parser_unit.sv */
// SOCKS5 server handshake parser, top level.
// Depends on s5hp_pkg.
//
// Usage:
//  Input channel (in_valid/in_stall) takes one client byte per transaction
//  with conn_start (restart at the greeting) and peer_closed (client gone).
//  Output channel (out_valid/out_stall) gives result items: reply bytes,
//  raw destination address bytes and a final outcome; last_of_run marks the
//  final result caused by one input byte.
//  The first result of a byte passes the input register, then the result
//  register, before it is offered. Throughput: one byte per cycle unless a
//  pending burst holds the input register. A byte causing n results holds
//  the result register until all are taken (n up to 11 at the end of a
//  handshake); bytes causing no result pass the parser even during a burst.
//  in_stall comes from a registered skid stage only, so it never follows
//  out_stall combinationally.
//  Reset: the parser waits for the greeting version byte, no result pending.
//  When the receiver stalls, the current result holds steady and input
//  backs up into the input and skid registers before in_stall rises.
module socks5_server_handshake_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        conn_start,
	input  logic        peer_closed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  byte_value,
	output logic [1:0]  addr_type,
	output logic [15:0] dst_port,
	output logic [2:0]  outcome,
	output logic        last_of_run
);
	import s5hp_pkg::*;

	typedef enum logic [3:0] {
		PH_GVER  = 4'd0,
		PH_NMETH = 4'd1,
		PH_METH  = 4'd2,
		PH_RVER  = 4'd3,
		PH_RCMD  = 4'd4,
		PH_RRSV  = 4'd5,
		PH_RATYP = 4'd6,
		PH_DLEN  = 4'd7,
		PH_ADDR  = 4'd8,
		PH_PHI   = 4'd9,
		PH_PLO   = 4'd10,
		PH_DONE  = 4'd11
	} phase_t;

	// Input and skid registers
	logic       s1_v_s1;
	logic [7:0] rx_byte_s1;
	logic       conn_start_s1;
	logic       peer_closed_s1;
	logic       skid_v_q;
	logic [7:0] skid_byte_q;
	logic       skid_start_q;
	logic       skid_closed_q;

	// Parser state
	phase_t     phase_q;
	logic [7:0] remaining_q;
	logic       auth_none_q;
	logic       version_ok_q;
	logic [7:0] command_q;
	logic [1:0] addr_kind_q;
	logic [7:0] port_high_q;

	// Result register (burst being emitted)
	logic             em_v_s2;
	burst_t           burst_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [7:0]       byte_s2;
	logic [1:0]       atype_s2;
	logic [15:0]      port_s2;
	logic [2:0]       oc_s2;

	// Decode of the byte in the input register
	phase_t     ph_e, ph_n;
	logic [7:0] rc_e, rc_n;
	logic       auth_e, auth_n;
	logic       ver_e, ver_n;
	logic [7:0] cmd_e, cmd_n;
	logic [1:0] ak_e, ak_n;
	logic [7:0] phi_e, phi_n;
	burst_t     bt;
	logic [7:0] bt_byte;
	logic [15:0] bt_port;
	logic [2:0] bt_oc;
	logic [7:0] rc_dec;
	logic       auth_upd;

	logic in_acc, out_acc, em_last, em_free, take, s1_free;

	always_comb begin
		// conn_start restarts from the reset state before this byte
		ph_e   = conn_start_s1 ? PH_GVER : phase_q;
		rc_e   = conn_start_s1 ? 8'd0 : remaining_q;
		auth_e = conn_start_s1 ? 1'b0 : auth_none_q;
		ver_e  = conn_start_s1 ? 1'b0 : version_ok_q;
		cmd_e  = conn_start_s1 ? 8'd0 : command_q;
		ak_e   = conn_start_s1 ? AT_IPV4 : addr_kind_q;
		phi_e  = conn_start_s1 ? 8'd0 : port_high_q;

		ph_n = ph_e; rc_n = rc_e; auth_n = auth_e; ver_n = ver_e;
		cmd_n = cmd_e; ak_n = ak_e; phi_n = phi_e;
		bt = BURST_NONE; bt_byte = 8'd0; bt_port = 16'd0; bt_oc = OC_READY;
		rc_dec   = rc_e - 8'd1;
		auth_upd = auth_e | (rx_byte_s1 == METHOD_NOAUTH);

		if (peer_closed_s1) begin
			if (ph_e != PH_DONE) begin
				bt = BURST_FIN; bt_oc = OC_CLOSED; ph_n = PH_DONE;
			end
		end else begin
			case (ph_e)
				PH_GVER: begin
					ver_n = (rx_byte_s1 == SOCKS_VER);
					ph_n  = PH_NMETH;
				end
				PH_NMETH: begin
					if (!ver_e) begin
						bt = BURST_FIN; bt_oc = OC_BAD_VER; ph_n = PH_DONE;
					end else if (rx_byte_s1 == 8'd0) begin
						bt = BURST_REJECT; bt_oc = OC_NO_METH; ph_n = PH_DONE;
					end else begin
						rc_n = rx_byte_s1; auth_n = 1'b0; ph_n = PH_METH;
					end
				end
				PH_METH: begin
					auth_n = auth_upd;
					rc_n   = rc_dec;
					if (rc_dec == 8'd0) begin
						if (auth_upd) begin
							bt = BURST_ACCEPT; ph_n = PH_RVER;
						end else begin
							bt = BURST_REJECT; bt_oc = OC_NO_METH; ph_n = PH_DONE;
						end
					end
				end
				PH_RVER: begin
					ver_n = (rx_byte_s1 == SOCKS_VER);
					ph_n  = PH_RCMD;
				end
				PH_RCMD: begin
					cmd_n = rx_byte_s1; ph_n = PH_RRSV;
				end
				PH_RRSV: begin
					ph_n = PH_RATYP;
				end
				PH_RATYP: begin
					// version, then command, then address type
					if (!ver_e) begin
						bt = BURST_FIN; bt_oc = OC_BAD_VER; ph_n = PH_DONE;
					end else if (cmd_e != CMD_CONNECT) begin
						bt = BURST_REPLY10; bt_byte = REP_CMD_UNSUP;
						bt_oc = OC_BAD_CMD; ph_n = PH_DONE;
					end else if (rx_byte_s1 == ATYP_IPV4) begin
						ak_n = AT_IPV4; rc_n = IPV4_ADDR_LEN; ph_n = PH_ADDR;
					end else if (rx_byte_s1 == ATYP_DOMAIN) begin
						ak_n = AT_DOMAIN; ph_n = PH_DLEN;
					end else if (rx_byte_s1 == ATYP_IPV6) begin
						ak_n = AT_IPV6; rc_n = IPV6_ADDR_LEN; ph_n = PH_ADDR;
					end else begin
						bt = BURST_REPLY10; bt_byte = REP_ATYP_UNSUP;
						bt_oc = OC_BAD_ATYP; ph_n = PH_DONE;
					end
				end
				PH_DLEN: begin
					// empty domain goes straight to the port
					rc_n = rx_byte_s1;
					ph_n = (rx_byte_s1 == 8'd0) ? PH_PHI : PH_ADDR;
				end
				PH_ADDR: begin
					bt = BURST_ADDR; bt_byte = rx_byte_s1;
					rc_n = rc_dec;
					if (rc_dec == 8'd0) ph_n = PH_PHI;
				end
				PH_PHI: begin
					phi_n = rx_byte_s1; ph_n = PH_PLO;
				end
				PH_PLO: begin
					bt = BURST_REPLY10; bt_byte = REP_SUCCEEDED;
					bt_port = {phi_e, rx_byte_s1}; bt_oc = OC_READY; ph_n = PH_DONE;
				end
				PH_DONE: begin
					ph_n = PH_DONE;
				end
				default: begin
					ph_n = PH_DONE;
				end
			endcase
		end
	end

	// Handshake control
	assign in_stall  = skid_v_q;
	assign in_acc    = in_valid && !skid_v_q;
	assign out_valid = em_v_s2;
	assign out_acc   = em_v_s2 && !out_stall;
	assign em_last   = (idx_s2 == burst_last_idx(burst_s2));
	assign em_free   = !em_v_s2 || (out_acc && em_last);
	assign take      = s1_v_s1 && ((bt == BURST_NONE) || em_free);
	assign s1_free   = !s1_v_s1 || take;

	// Input register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (s1_free) begin
			s1_v_s1  <= skid_v_q || in_acc;
			skid_v_q <= 1'b0;
		end else if (in_acc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			if (skid_v_q) begin
				rx_byte_s1     <= skid_byte_q;
				conn_start_s1  <= skid_start_q;
				peer_closed_s1 <= skid_closed_q;
			end else if (in_acc) begin
				rx_byte_s1     <= rx_byte;
				conn_start_s1  <= conn_start;
				peer_closed_s1 <= peer_closed;
			end
		end else if (in_acc) begin
			skid_byte_q   <= rx_byte;
			skid_start_q  <= conn_start;
			skid_closed_q <= peer_closed;
		end
	end

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_GVER;
			remaining_q  <= 8'd0;
			auth_none_q  <= 1'b0;
			version_ok_q <= 1'b0;
			command_q    <= 8'd0;
			addr_kind_q  <= AT_IPV4;
			port_high_q  <= 8'd0;
		end else if (take) begin
			phase_q      <= ph_n;
			remaining_q  <= rc_n;
			auth_none_q  <= auth_n;
			version_ok_q <= ver_n;
			command_q    <= cmd_n;
			addr_kind_q  <= ak_n;
			port_high_q  <= phi_n;
		end
	end

	// Result register: load a burst, step through it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_v_s2  <= 1'b0;
			burst_s2 <= BURST_NONE;
			idx_s2   <= '0;
		end else if (take && (bt != BURST_NONE)) begin
			em_v_s2  <= 1'b1;
			burst_s2 <= bt;
			idx_s2   <= '0;
		end else if (out_acc) begin
			if (em_last) begin
				em_v_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && (bt != BURST_NONE)) begin
			byte_s2  <= bt_byte;
			atype_s2 <= ak_e;
			port_s2  <= bt_port;
			oc_s2    <= bt_oc;
		end
	end

	// Result fields from the burst and its index
	always_comb begin
		kind        = KIND_REPLY;
		byte_value  = 8'd0;
		addr_type   = AT_IPV4;
		dst_port    = 16'd0;
		outcome     = OC_READY;
		last_of_run = em_last;
		case (burst_s2)
			BURST_ADDR: begin
				kind       = KIND_ADDR;
				byte_value = byte_s2;
				addr_type  = atype_s2;
			end
			BURST_FIN: begin
				kind      = KIND_OUTCOME;
				addr_type = atype_s2;
				outcome   = oc_s2;
			end
			BURST_REJECT: begin
				if (em_last) begin
					kind      = KIND_OUTCOME;
					addr_type = atype_s2;
					outcome   = oc_s2;
				end else begin
					byte_value = (idx_s2 == '0) ? SOCKS_VER : METHOD_NONE;
				end
			end
			BURST_ACCEPT: begin
				byte_value = (idx_s2 == '0) ? SOCKS_VER : METHOD_NOAUTH;
			end
			BURST_REPLY10: begin
				if (em_last) begin
					kind      = KIND_OUTCOME;
					addr_type = atype_s2;
					dst_port  = port_s2;
					outcome   = oc_s2;
				end else begin
					byte_value = reply10_byte(idx_s2, byte_s2);
				end
			end
			default: begin
				kind = KIND_REPLY;
			end
		endcase
	end

	// Checks
	a_skid_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(s1_v_s1 && !take))
		else $error("skid filled while input register was free");

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		em_v_s2 |-> (idx_s2 <= burst_last_idx(burst_s2)) && (burst_s2 != BURST_NONE))
		else $error("result index beyond burst length");

	a_outcome_only_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_OUTCOME) |-> (outcome == OC_READY && dst_port == 16'd0))
		else $error("outcome fields set on a non-outcome result");

	a_outcome_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_OUTCOME) |-> last_of_run)
		else $error("outcome result not marked last");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the SOCKS5 server handshake parser unit.
// Directed table, then random handshakes, checked against an in-bench predictor.
// Depends on s5hp_pkg and socks5_server_handshake_parser_unit.
`timescale 1ns / 1ps

module testbench;
	import s5hp_pkg::*;

	localparam int ITEM_TARGET  = 450;
	localparam int MAX_IDLE     = 6;
	localparam int LONG_HOLD    = 200;
	localparam int QUIET_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 20;

	// Parser phases as tracked by the predictor
	typedef enum logic [3:0] {
		PH_GREET_VER, PH_METH_COUNT, PH_METHODS, PH_REQ_VER, PH_REQ_CMD, PH_REQ_RSV,
		PH_REQ_ATYP, PH_DOM_LEN, PH_ADDR, PH_PORT_HI, PH_PORT_LO, PH_DONE
	} parse_phase_t;

	// One client byte, with an optional hand-typed final outcome
	typedef struct packed {
		logic [7:0] rx;
		logic       cs;
		logic       pc;
		logic       oc_typed;
		logic [2:0] oc;
	} stim_row_t;

	// One result item as seen on the output channel
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  val;
		logic [1:0]  atype;
		logic [15:0] port;
		logic [2:0]  oc;
		logic        last;
	} hs_result_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte     = 8'h00;
	logic        conn_start  = 1'b0;
	logic        peer_closed = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic [1:0]  addr_type;
	logic [15:0] dst_port;
	logic [2:0]  outcome;
	logic        last_of_run;

	// Predictor state
	parse_phase_t parse_phase;
	logic [7:0]   bytes_left;
	logic         noauth_offered;
	logic         version_good;
	logic [7:0]   cmd_seen;
	logic [1:0]   atype_seen;
	logic [7:0]   port_hi_seen;

	hs_result_t awaited_results[$];
	stim_row_t  client_bytes[$];

	int  fail_count   = 0;
	int  sent_items   = 0;
	int  quiet_cycles = 0;
	bit  sender_idle   = 1'b1;
	bit  receiver_idle = 1'b1;
	bit  hold_req      = 1'b0;

	// Directed transactions: close before any byte, after-end behaviour,
	// greeting faults, method scan, command and address-type rejects
	stim_row_t directed_rows [23] = '{
		'{8'hFF, 1'b0, 1'b1, 1'b1, OC_CLOSED},   // close straight after reset
		'{8'h00, 1'b0, 1'b1, 1'b0, OC_READY},    // close after the end: nothing
		'{8'h05, 1'b0, 1'b0, 1'b0, OC_READY},    // byte after the end: ignored
		'{8'h04, 1'b1, 1'b0, 1'b0, OC_READY},    // wrong greeting version
		'{8'h01, 1'b0, 1'b0, 1'b1, OC_BAD_VER},  // judged on the count byte
		'{8'h05, 1'b1, 1'b0, 1'b0, OC_READY},
		'{8'h00, 1'b0, 1'b0, 1'b1, OC_NO_METH},  // zero methods
		'{8'h05, 1'b1, 1'b0, 1'b0, OC_READY},
		'{8'h02, 1'b0, 1'b0, 1'b0, OC_READY},
		'{8'hFF, 1'b0, 1'b0, 1'b0, OC_READY},
		'{8'h00, 1'b0, 1'b0, 1'b0, OC_READY},    // no-auth offered last
		'{8'h05, 1'b0, 1'b0, 1'b0, OC_READY},
		'{8'h02, 1'b0, 1'b0, 1'b0, OC_READY},    // unsupported command
		'{8'h00, 1'b0, 1'b0, 1'b0, OC_READY},
		'{8'h07, 1'b0, 1'b0, 1'b1, OC_BAD_CMD},  // command wins over address type
		'{8'h05, 1'b1, 1'b0, 1'b0, OC_READY},
		'{8'h01, 1'b0, 1'b0, 1'b0, OC_READY},
		'{8'h00, 1'b0, 1'b0, 1'b0, OC_READY},
		'{8'h05, 1'b0, 1'b0, 1'b0, OC_READY},
		'{8'h01, 1'b0, 1'b0, 1'b0, OC_READY},
		'{8'hFF, 1'b0, 1'b0, 1'b0, OC_READY},
		'{8'hAB, 1'b0, 1'b0, 1'b1, OC_BAD_ATYP}, // unknown address type
		'{8'h00, 1'b1, 1'b1, 1'b1, OC_CLOSED}    // restart and close together
	};

	socks5_server_handshake_parser_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic void restart_parser();
		parse_phase    = PH_GREET_VER;
		bytes_left     = 8'h00;
		noauth_offered = 1'b0;
		version_good   = 1'b0;
		cmd_seen       = 8'h00;
		atype_seen     = AT_IPV4;
		port_hi_seen   = 8'h00;
	endfunction

	function automatic void add_result(input logic [1:0] k, input logic [7:0] v,
			input logic [1:0] at, input logic [15:0] p, input logic [2:0] o);
		hs_result_t r;
		r.kind  = k;
		r.val   = v;
		r.atype = at;
		r.port  = p;
		r.oc    = o;
		r.last  = 1'b0;
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	// Ends the handshake with an outcome item
	function automatic void conclude(input logic [15:0] p, input logic [2:0] o);
		parse_phase = PH_DONE;
		add_result(KIND_OUTCOME, 8'h00, atype_seen, p, o);
	endfunction

	// Request reply: 05 REP 00 01 then six zero bytes
	function automatic void add_reply10(input logic [7:0] code);
		logic [7:0] v;
		for (int i = 0; i < 10; i++) begin
			case (i)
				0:       v = SOCKS_VER;
				1:       v = code;
				3:       v = ATYP_IPV4;
				default: v = 8'h00;
			endcase
			add_result(KIND_REPLY, v, AT_IPV4, 16'h0000, OC_READY);
		end
	endfunction

	function automatic void parse_client_byte(input stim_row_t t);
		int first;
		first = awaited_results.size();
		if (t.cs)
			restart_parser();
		if (t.pc) begin
			if (parse_phase != PH_DONE)
				conclude(16'h0000, OC_CLOSED);
		end else begin
			case (parse_phase)
				PH_GREET_VER: begin
					version_good = (t.rx == SOCKS_VER);
					parse_phase  = PH_METH_COUNT;
				end
				PH_METH_COUNT: begin
					if (!version_good) begin
						conclude(16'h0000, OC_BAD_VER);
					end else if (t.rx == 8'h00) begin
						add_result(KIND_REPLY, SOCKS_VER, AT_IPV4, 16'h0000, OC_READY);
						add_result(KIND_REPLY, METHOD_NONE, AT_IPV4, 16'h0000, OC_READY);
						conclude(16'h0000, OC_NO_METH);
					end else begin
						bytes_left     = t.rx;
						noauth_offered = 1'b0;
						parse_phase    = PH_METHODS;
					end
				end
				PH_METHODS: begin
					if (t.rx == METHOD_NOAUTH)
						noauth_offered = 1'b1;
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 8'h00) begin
						add_result(KIND_REPLY, SOCKS_VER, AT_IPV4, 16'h0000, OC_READY);
						if (noauth_offered) begin
							add_result(KIND_REPLY, METHOD_NOAUTH, AT_IPV4, 16'h0000, OC_READY);
							parse_phase = PH_REQ_VER;
						end else begin
							add_result(KIND_REPLY, METHOD_NONE, AT_IPV4, 16'h0000, OC_READY);
							conclude(16'h0000, OC_NO_METH);
						end
					end
				end
				PH_REQ_VER: begin
					version_good = (t.rx == SOCKS_VER);
					parse_phase  = PH_REQ_CMD;
				end
				PH_REQ_CMD: begin
					cmd_seen    = t.rx;
					parse_phase = PH_REQ_RSV;
				end
				PH_REQ_RSV: parse_phase = PH_REQ_ATYP;
				// all request checks fall on the address-type byte
				PH_REQ_ATYP: begin
					if (!version_good) begin
						conclude(16'h0000, OC_BAD_VER);
					end else if (cmd_seen != CMD_CONNECT) begin
						add_reply10(REP_CMD_UNSUP);
						conclude(16'h0000, OC_BAD_CMD);
					end else begin
						case (t.rx)
							ATYP_IPV4: begin
								atype_seen  = AT_IPV4;
								bytes_left  = IPV4_ADDR_LEN;
								parse_phase = PH_ADDR;
							end
							ATYP_DOMAIN: begin
								atype_seen  = AT_DOMAIN;
								parse_phase = PH_DOM_LEN;
							end
							ATYP_IPV6: begin
								atype_seen  = AT_IPV6;
								bytes_left  = IPV6_ADDR_LEN;
								parse_phase = PH_ADDR;
							end
							default: begin
								add_reply10(REP_ATYP_UNSUP);
								conclude(16'h0000, OC_BAD_ATYP);
							end
						endcase
					end
				end
				// length byte is consumed, not passed on
				PH_DOM_LEN: begin
					bytes_left  = t.rx;
					parse_phase = (t.rx == 8'h00) ? PH_PORT_HI : PH_ADDR;
				end
				PH_ADDR: begin
					add_result(KIND_ADDR, t.rx, atype_seen, 16'h0000, OC_READY);
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 8'h00)
						parse_phase = PH_PORT_HI;
				end
				PH_PORT_HI: begin
					port_hi_seen = t.rx;
					parse_phase  = PH_PORT_LO;
				end
				PH_PORT_LO: begin
					add_reply10(REP_SUCCEEDED);
					conclude({port_hi_seen, t.rx}, OC_READY);
				end
				default: parse_phase = PH_DONE;
			endcase
		end
		if (awaited_results.size() > first)
			awaited_results[awaited_results.size() - 1].last = 1'b1;
	endfunction

	// ---------------- stimulus ----------------

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic void push_stim(input logic [7:0] b, input logic cs, input logic pc);
		stim_row_t t;
		t.rx       = b;
		t.cs       = cs;
		t.pc       = pc;
		t.oc_typed = 1'b0;
		t.oc       = OC_READY;
		client_bytes.insert(client_bytes.size(), t);
	endfunction

	// Mostly well-formed handshakes with random content; some noise
	function automatic void queue_handshake();
		int n, noauth_at, alen;
		logic [7:0] ver, cmd, atyp;
		if (chance(10)) begin
			n = $urandom_range(1, 12);
			repeat (n)
				push_stim(8'($urandom), chance(10), chance(8));
			return;
		end
		// greeting
		ver = chance(8) ? 8'($urandom) : SOCKS_VER;
		push_stim(ver, 1'b1, chance(2));
		if (chance(2))
			n = $urandom_range(6, 255);
		else if (chance(8))
			n = 0;
		else
			n = $urandom_range(1, 5);
		push_stim(8'(n), 1'b0, chance(2));
		if (ver != SOCKS_VER || n == 0)
			return;
		noauth_at = chance(80) ? $urandom_range(0, n - 1) : -1;
		for (int i = 0; i < n; i++)
			push_stim((i == noauth_at) ? METHOD_NOAUTH : 8'($urandom), 1'b0, chance(2));
		if (noauth_at < 0)
			return;
		// request
		ver = chance(8) ? 8'($urandom) : SOCKS_VER;
		cmd = chance(10) ? 8'($urandom) : CMD_CONNECT;
		case ($urandom_range(0, 9))
			0, 1, 2: atyp = ATYP_IPV4;
			3, 4, 5: atyp = ATYP_DOMAIN;
			6, 7, 8: atyp = ATYP_IPV6;
			default: atyp = 8'($urandom);
		endcase
		push_stim(ver, 1'b0, chance(2));
		push_stim(cmd, 1'b0, chance(2));
		push_stim(8'($urandom), 1'b0, chance(2));
		push_stim(atyp, 1'b0, chance(2));
		if (ver != SOCKS_VER || cmd != CMD_CONNECT)
			return;
		case (atyp)
			ATYP_IPV4: alen = IPV4_ADDR_LEN;
			ATYP_IPV6: alen = IPV6_ADDR_LEN;
			ATYP_DOMAIN: begin
				if (chance(20))
					alen = 0;
				else if (chance(3))
					alen = $urandom_range(9, 255);
				else
					alen = $urandom_range(1, 8);
				push_stim(8'(alen), 1'b0, chance(2));
			end
			default: return;
		endcase
		repeat (alen)
			push_stim(8'($urandom), 1'b0, chance(2));
		push_stim(8'($urandom), 1'b0, chance(2));
		push_stim(8'($urandom), 1'b0, chance(2));
	endfunction

	// Offers one transaction and predicts its results once accepted
	task automatic offer_transaction(input stim_row_t t);
		int gap;
		gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		rx_byte     <= t.rx;
		conn_start  <= t.cs;
		peer_closed <= t.pc;
		do
			@(posedge clk);
		while (in_stall);
		sent_items++;
		parse_client_byte(t);
		if (t.oc_typed && (awaited_results.size() == 0 ||
				awaited_results[$].kind != KIND_OUTCOME || awaited_results[$].oc != t.oc)) begin
			$error("directed outcome: expected %0d, not predicted", t.oc);
			fail_count++;
		end
	endtask

	initial begin
		restart_parser();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_transaction(directed_rows[i]);

		// first stretch: no idling, with one long receiver hold-off
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		hold_req      = 1'b1;
		while (sent_items < ITEM_TARGET) begin
			if (sent_items > 170)
				sender_idle = 1'b1;
			if (sent_items > 300)
				receiver_idle = 1'b1;
			queue_handshake();
			while (client_bytes.size() != 0)
				offer_transaction(client_bytes.pop_front());
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// ---------------- result side ----------------

	// Receiver: random stall before each transaction once receiver_idle is set, one long hold on request
	initial begin
		int stall_len;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (LONG_HOLD) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			stall_len = receiver_idle ? $urandom_range(0, MAX_IDLE) : 0;
			repeat (stall_len) begin
				out_stall <= 1'b1;
				@(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		hs_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: kind %0d byte %02h outcome %0d",
					kind, byte_value, outcome);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("kind", want.kind, kind);
				check_field("byte_value", want.val, byte_value);
				check_field("addr_type", want.atype, addr_type);
				check_field("dst_port", want.port, dst_port);
				check_field("outcome", want.oc, outcome);
				check_field("last_of_run", want.last, last_of_run);
			end
		end
	end

	// Watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
